// ===== rtl/core/tlca_pkg.sv =====
// ----------------------------------------------------------------------------
// tlca_pkg: shared types and constants for the tree ancestor engine
// Operation and status codes, field widths and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package tlca_pkg;

    localparam int NODE_W = 10;
    localparam int LEN_W  = 11;
    localparam int CNT_W  = 11;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam int DEF_MAX_NODES   = 1024;
    localparam int DEF_LIFT_LEVELS = 10;

    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(1024);

    typedef logic [OP_W-1:0] op_t;
    typedef logic [ST_W-1:0] status_t;

    localparam op_t OP_ADD   = 2'd0;
    localparam op_t OP_BUILD = 2'd1;
    localparam op_t OP_LCA   = 2'd2;
    localparam op_t OP_LEVEL = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_RANGE = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/tree_lca_binary_lifting.sv =====
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting: tree ancestor engine with binary lifting
//
// Command channel: an item transfers when start is high and busy is low.
// Each item yields one result, shown for one cycle with done high; the
// receiver takes it then and cannot stall it. cfg_valid/cfg_ready write
// node_count; cfg_ready is always high, write only while idle.
// Sequence of work per item:
//   add edge and any out-of-range item: answered from idle without leaving it.
//   build: clears the seen flags of all MAX_NODES nodes, sets up the root,
//          walks the tree depth first, scanning every stored edge for each
//          reached node, then fills each higher lifting level for all nodes.
//   lca query: reads both depths and lifts the deeper node; when the climb
//          misses the other node, climbs both from the top level down.
//   level ancestor: lifts node_a by steps_up, one table read per set bit.
// One item at a time; for build and in-range queries busy stays high until
// the result is shown; add edge and out-of-range items leave busy low.
// Reset: asynchronous, active low. After reset a clearing pass over all MAX_NODES entries
// zeroes level 0 of the table and the depths; busy is high meanwhile. Configuration writes are taken during that pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_lca_binary_lifting #(
    parameter int MAX_NODES   = tlca_pkg::DEF_MAX_NODES,
    parameter int LIFT_LEVELS = tlca_pkg::DEF_LIFT_LEVELS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [tlca_pkg::OP_W-1:0]   operation,
    input  wire logic [tlca_pkg::NODE_W-1:0] node_a,
    input  wire logic [tlca_pkg::NODE_W-1:0] node_b,
    input  wire logic [tlca_pkg::NODE_W-1:0] root,
    input  wire logic [tlca_pkg::NODE_W-1:0] steps_up,
    output logic                             done,
    output logic [tlca_pkg::NODE_W-1:0]      result_node,
    output logic [tlca_pkg::LEN_W-1:0]       path_length,
    output logic [tlca_pkg::ST_W-1:0]        status,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [tlca_pkg::CNT_W-1:0]  cfg_data
);

    localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int LW  = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int EW  = $clog2(MAX_NODES + 1);
    localparam int XW  = (EW > tlca_pkg::CNT_W) ? EW : tlca_pkg::CNT_W;
    localparam int TAW = NW + LW;
    localparam int EDW = 2 * tlca_pkg::NODE_W;
    localparam logic [31:0] KCAP = (32'd1 << LIFT_LEVELS) - 32'd1;

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_B_SEEN = 5'd2;
    localparam logic [4:0] S_B_INIT = 5'd3;
    localparam logic [4:0] S_B_POP  = 5'd4;
    localparam logic [4:0] S_B_V    = 5'd5;
    localparam logic [4:0] S_B_DV   = 5'd6;
    localparam logic [4:0] S_B_E    = 5'd7;
    localparam logic [4:0] S_B_ED   = 5'd8;
    localparam logic [4:0] S_B_SN   = 5'd9;
    localparam logic [4:0] S_L_R1   = 5'd10;
    localparam logic [4:0] S_L_R2   = 5'd11;
    localparam logic [4:0] S_L_W    = 5'd12;
    localparam logic [4:0] S_Q_RA   = 5'd13;
    localparam logic [4:0] S_Q_RB   = 5'd14;
    localparam logic [4:0] S_Q_SW   = 5'd15;
    localparam logic [4:0] S_C_STEP = 5'd16;
    localparam logic [4:0] S_C_WAIT = 5'd17;
    localparam logic [4:0] S_C_END  = 5'd18;
    localparam logic [4:0] S_Q_RV   = 5'd19;
    localparam logic [4:0] S_Q_RU   = 5'd20;
    localparam logic [4:0] S_Q_CMP  = 5'd21;
    localparam logic [4:0] S_Q_P0   = 5'd22;
    localparam logic [4:0] S_Q_P1   = 5'd23;
    localparam logic [4:0] S_Q_DP   = 5'd24;
    localparam logic [4:0] S_Q_FIN  = 5'd25;

    function automatic logic [LIFT_LEVELS-1:0] sat_k(input logic [31:0] x);
        sat_k = (x > KCAP) ? LIFT_LEVELS'(KCAP) : LIFT_LEVELS'(x);
    endfunction

    // memories
    logic [NW-1:0]  tbl_mem [0:(LIFT_LEVELS << NW) - 1];
    logic [NW-1:0]  dep_mem [0:MAX_NODES-1];
    logic [EDW-1:0] edg_mem [0:MAX_NODES-1];
    logic [NW-1:0]  stk_mem [0:MAX_NODES-1];
    logic           seen_mem[0:MAX_NODES-1];

    logic           tbl_we, dep_we, edg_we, stk_we, seen_we, seen_wdata;
    logic [TAW-1:0] tbl_raddr, tbl_waddr;
    logic [NW-1:0]  tbl_wdata, tbl_q, tbl_rdata;
    logic [NW-1:0]  dep_raddr, dep_waddr, dep_wdata, dep_rdata;
    logic [NW-1:0]  edg_raddr, edg_waddr;
    logic [EDW-1:0] edg_wdata, edg_rdata;
    logic [NW-1:0]  stk_raddr, stk_waddr, stk_wdata, stk_rdata;
    logic [NW-1:0]  seen_raddr, seen_waddr;
    logic           seen_rdata;

    // control state
    logic [4:0]              state_reg, state_next;
    logic [NW-1:0]           cnt_reg, cnt_next;
    logic [LW-1:0]           lvl_reg, lvl_next;
    logic [EW-1:0]           sp_reg, sp_next;
    logic [EW-1:0]           e_reg, e_next;
    logic [EW-1:0]           edge_total_reg, edge_total_next;
    logic                    lifted_reg, lifted_next;
    logic                    tbl_hi_reg, tbl_hi_next;
    logic [tlca_pkg::CNT_W-1:0] node_count_reg;
    logic                    done_reg, done_next;

    // payload
    logic [tlca_pkg::NODE_W-1:0] result_node_reg, result_node_next;
    logic [tlca_pkg::LEN_W-1:0]  path_length_reg, path_length_next;
    tlca_pkg::status_t           status_reg, status_next;
    tlca_pkg::op_t               op_reg, op_next;
    logic [NW-1:0] a_reg, a_next, b_reg, b_next, root_reg, root_next;
    logic [NW-1:0] v_reg, v_next, u_reg, u_next, w_reg, w_next;
    logic [NW-1:0] tv_reg, tv_next, p_reg, p_next;
    logic [NW-1:0] dv_reg, dv_next, da_reg, da_next, db_reg, db_next;
    logic [LIFT_LEVELS-1:0] k_reg, k_next;

    logic [XW-1:0] cfg_x, live_n;
    logic a_ok, b_ok, r_ok, ea_ok, eb_ok;
    logic [tlca_pkg::NODE_W-1:0] ea, eb;
    logic [NW-1:0] sp_dec;
    logic [NW:0]   dist_sum, dist_sub;

    assign cfg_x  = XW'(node_count_reg);
    assign live_n = (cfg_x == '0) ? XW'(1)
                  : (cfg_x > XW'(MAX_NODES)) ? XW'(MAX_NODES) : cfg_x;
    assign a_ok   = XW'(node_a) < live_n;
    assign b_ok   = XW'(node_b) < live_n;
    assign r_ok   = XW'(root) < live_n;
    assign ea     = edg_rdata[tlca_pkg::NODE_W-1:0];
    assign eb     = edg_rdata[EDW-1:tlca_pkg::NODE_W];
    assign ea_ok  = XW'(ea) < live_n;
    assign eb_ok  = XW'(eb) < live_n;
    assign sp_dec = NW'(sp_reg - EW'(1));
    assign dist_sum = {1'b0, da_reg} + {1'b0, db_reg};
    assign dist_sub = {dep_rdata, 1'b0};
    assign tbl_rdata = tbl_hi_reg ? '0 : tbl_q;
    assign tbl_hi_next = (tbl_raddr[TAW-1:NW] != '0) && !lifted_reg;

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[tbl_waddr] <= tbl_wdata;
        tbl_q <= tbl_mem[tbl_raddr];
        if (dep_we)
            dep_mem[dep_waddr] <= dep_wdata;
        dep_rdata <= dep_mem[dep_raddr];
        if (edg_we)
            edg_mem[edg_waddr] <= edg_wdata;
        edg_rdata <= edg_mem[edg_raddr];
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        stk_rdata <= stk_mem[stk_raddr];
        if (seen_we)
            seen_mem[seen_waddr] <= seen_wdata;
        seen_rdata <= seen_mem[seen_raddr];
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        lvl_next         = lvl_reg;
        sp_next          = sp_reg;
        e_next           = e_reg;
        edge_total_next  = edge_total_reg;
        lifted_next      = lifted_reg;
        done_next        = 1'b0;
        result_node_next = result_node_reg;
        path_length_next = path_length_reg;
        status_next      = status_reg;
        op_next          = op_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        root_next        = root_reg;
        v_next           = v_reg;
        u_next           = u_reg;
        w_next           = w_reg;
        tv_next          = tv_reg;
        p_next           = p_reg;
        dv_next          = dv_reg;
        da_next          = da_reg;
        db_next          = db_reg;
        k_next           = k_reg;

        tbl_we     = 1'b0;
        tbl_raddr  = '0;
        tbl_waddr  = '0;
        tbl_wdata  = '0;
        dep_we     = 1'b0;
        dep_raddr  = '0;
        dep_waddr  = '0;
        dep_wdata  = '0;
        edg_we     = 1'b0;
        edg_raddr  = '0;
        edg_waddr  = '0;
        edg_wdata  = '0;
        stk_we     = 1'b0;
        stk_raddr  = '0;
        stk_waddr  = '0;
        stk_wdata  = '0;
        seen_we    = 1'b0;
        seen_raddr = '0;
        seen_waddr = '0;
        seen_wdata = 1'b0;

        unique case (state_reg)
            S_CLR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = {LW'(0), cnt_reg};
                dep_we    = 1'b1;
                dep_waddr = cnt_reg;
                cnt_next  = cnt_reg + NW'(1);
                if (cnt_reg == NW'(MAX_NODES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next          = operation;
                    a_next           = NW'(node_a);
                    b_next           = NW'(node_b);
                    root_next        = NW'(root);
                    result_node_next = '0;
                    path_length_next = '0;
                    status_next      = tlca_pkg::ST_OK;
                    unique case (operation)
                        tlca_pkg::OP_ADD:
                        begin
                            done_next = 1'b1;
                            if (!(a_ok && b_ok))
                                status_next = tlca_pkg::ST_RANGE;
                            else if (edge_total_reg >= EW'(MAX_NODES))
                                status_next = tlca_pkg::ST_FULL;
                            else
                            begin
                                edg_we          = 1'b1;
                                edg_waddr       = edge_total_reg[NW-1:0];
                                edg_wdata       = {node_b, node_a};
                                edge_total_next = edge_total_reg + EW'(1);
                            end
                        end
                        tlca_pkg::OP_BUILD:
                        begin
                            if (r_ok)
                            begin
                                cnt_next   = '0;
                                state_next = S_B_SEEN;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = tlca_pkg::ST_RANGE;
                            end
                        end
                        tlca_pkg::OP_LCA:
                        begin
                            if (a_ok && b_ok)
                                state_next = S_Q_RA;
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = tlca_pkg::ST_RANGE;
                            end
                        end
                        default:
                        begin
                            if (a_ok)
                            begin
                                v_next     = NW'(node_a);
                                k_next     = sat_k(32'(steps_up));
                                lvl_next   = '0;
                                state_next = S_C_STEP;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = tlca_pkg::ST_RANGE;
                            end
                        end
                    endcase
                end
            end
            S_B_SEEN:
            begin
                seen_we    = 1'b1;
                seen_waddr = cnt_reg;
                cnt_next   = cnt_reg + NW'(1);
                if (cnt_reg == NW'(MAX_NODES - 1))
                    state_next = S_B_INIT;
            end
            S_B_INIT:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = {LW'(0), root_reg};
                tbl_wdata  = root_reg;
                dep_we     = 1'b1;
                dep_waddr  = root_reg;
                seen_we    = 1'b1;
                seen_waddr = root_reg;
                seen_wdata = 1'b1;
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = root_reg;
                sp_next    = EW'(1);
                state_next = S_B_POP;
            end
            S_B_POP:
            begin
                if (sp_reg == '0)
                begin
                    lifted_next = 1'b1;
                    if (LIFT_LEVELS == 1)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        lvl_next   = LW'(1);
                        cnt_next   = '0;
                        state_next = S_L_R1;
                    end
                end
                else
                begin
                    stk_raddr  = sp_dec;
                    sp_next    = sp_reg - EW'(1);
                    state_next = S_B_V;
                end
            end
            S_B_V:
            begin
                v_next     = stk_rdata;
                dep_raddr  = stk_rdata;
                state_next = S_B_DV;
            end
            S_B_DV:
            begin
                dv_next    = dep_rdata;
                e_next     = '0;
                state_next = S_B_E;
            end
            S_B_E:
            begin
                if (e_reg == edge_total_reg)
                    state_next = S_B_POP;
                else
                begin
                    edg_raddr  = e_reg[NW-1:0];
                    state_next = S_B_ED;
                end
            end
            S_B_ED:
            begin
                e_next     = e_reg + EW'(1);
                state_next = S_B_E;
                if (ea_ok && eb_ok)
                begin
                    if (NW'(ea) == v_reg)
                    begin
                        w_next     = NW'(eb);
                        seen_raddr = NW'(eb);
                        e_next     = e_reg;
                        state_next = S_B_SN;
                    end
                    else if (NW'(eb) == v_reg)
                    begin
                        w_next     = NW'(ea);
                        seen_raddr = NW'(ea);
                        e_next     = e_reg;
                        state_next = S_B_SN;
                    end
                end
            end
            S_B_SN:
            begin
                if (!seen_rdata)
                begin
                    seen_we    = 1'b1;
                    seen_waddr = w_reg;
                    seen_wdata = 1'b1;
                    tbl_we     = 1'b1;
                    tbl_waddr  = {LW'(0), w_reg};
                    tbl_wdata  = v_reg;
                    dep_we     = 1'b1;
                    dep_waddr  = w_reg;
                    dep_wdata  = dv_reg + NW'(1);
                    if (sp_reg != EW'(MAX_NODES))
                    begin
                        stk_we    = 1'b1;
                        stk_waddr = sp_reg[NW-1:0];
                        stk_wdata = w_reg;
                        sp_next   = sp_reg + EW'(1);
                    end
                end
                e_next     = e_reg + EW'(1);
                state_next = S_B_E;
            end
            S_L_R1:
            begin
                tbl_raddr  = {LW'(lvl_reg - LW'(1)), cnt_reg};
                state_next = S_L_R2;
            end
            S_L_R2:
            begin
                tbl_raddr  = {LW'(lvl_reg - LW'(1)), tbl_rdata};
                state_next = S_L_W;
            end
            S_L_W:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = {lvl_reg, cnt_reg};
                tbl_wdata  = tbl_rdata;
                cnt_next   = cnt_reg + NW'(1);
                state_next = S_L_R1;
                if (cnt_reg == NW'(MAX_NODES - 1))
                begin
                    cnt_next = '0;
                    if (lvl_reg == LW'(LIFT_LEVELS - 1))
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                        lvl_next = lvl_reg + LW'(1);
                end
            end
            S_Q_RA:
            begin
                dep_raddr  = a_reg;
                state_next = S_Q_RB;
            end
            S_Q_RB:
            begin
                da_next    = dep_rdata;
                dep_raddr  = b_reg;
                state_next = S_Q_SW;
            end
            S_Q_SW:
            begin
                db_next  = dep_rdata;
                lvl_next = '0;
                if (da_reg < dep_rdata)
                begin
                    v_next = b_reg;
                    u_next = a_reg;
                    k_next = sat_k(32'(dep_rdata - da_reg));
                end
                else
                begin
                    v_next = a_reg;
                    u_next = b_reg;
                    k_next = sat_k(32'(da_reg - dep_rdata));
                end
                state_next = S_C_STEP;
            end
            S_C_STEP:
            begin
                if (k_reg[lvl_reg])
                begin
                    tbl_raddr  = {lvl_reg, v_reg};
                    state_next = S_C_WAIT;
                end
                else if (lvl_reg == LW'(LIFT_LEVELS - 1))
                    state_next = S_C_END;
                else
                    lvl_next = lvl_reg + LW'(1);
            end
            S_C_WAIT:
            begin
                v_next = tbl_rdata;
                if (lvl_reg == LW'(LIFT_LEVELS - 1))
                    state_next = S_C_END;
                else
                begin
                    lvl_next   = lvl_reg + LW'(1);
                    state_next = S_C_STEP;
                end
            end
            S_C_END:
            begin
                if (op_reg == tlca_pkg::OP_LEVEL)
                begin
                    result_node_next = tlca_pkg::NODE_W'(v_reg);
                    done_next        = 1'b1;
                    state_next       = S_IDLE;
                end
                else if (v_reg == u_reg)
                begin
                    p_next     = v_reg;
                    state_next = S_Q_DP;
                end
                else
                begin
                    lvl_next   = LW'(LIFT_LEVELS - 1);
                    state_next = S_Q_RV;
                end
            end
            S_Q_RV:
            begin
                tbl_raddr  = {lvl_reg, v_reg};
                state_next = S_Q_RU;
            end
            S_Q_RU:
            begin
                tv_next    = tbl_rdata;
                tbl_raddr  = {lvl_reg, u_reg};
                state_next = S_Q_CMP;
            end
            S_Q_CMP:
            begin
                if (tv_reg != tbl_rdata)
                begin
                    v_next = tv_reg;
                    u_next = tbl_rdata;
                end
                if (lvl_reg == '0)
                    state_next = S_Q_P0;
                else
                begin
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = S_Q_RV;
                end
            end
            S_Q_P0:
            begin
                tbl_raddr  = {LW'(0), v_reg};
                state_next = S_Q_P1;
            end
            S_Q_P1:
            begin
                p_next     = tbl_rdata;
                state_next = S_Q_DP;
            end
            S_Q_DP:
            begin
                dep_raddr  = p_reg;
                state_next = S_Q_FIN;
            end
            S_Q_FIN:
            begin
                result_node_next = tlca_pkg::NODE_W'(p_reg);
                path_length_next = (dist_sum > dist_sub)
                                 ? tlca_pkg::LEN_W'(dist_sum - dist_sub) : '0;
                done_next        = 1'b1;
                state_next       = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            cnt_reg        <= '0;
            lvl_reg        <= '0;
            sp_reg         <= '0;
            e_reg          <= '0;
            edge_total_reg <= '0;
            lifted_reg     <= 1'b0;
            tbl_hi_reg     <= 1'b0;
            done_reg       <= 1'b0;
            op_reg         <= tlca_pkg::OP_ADD;
            node_count_reg <= tlca_pkg::NODE_COUNT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            lvl_reg        <= lvl_next;
            sp_reg         <= sp_next;
            e_reg          <= e_next;
            edge_total_reg <= edge_total_next;
            lifted_reg     <= lifted_next;
            tbl_hi_reg     <= tbl_hi_next;
            done_reg       <= done_next;
            op_reg         <= op_next;
            if (cfg_valid && cfg_ready)
                node_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        result_node_reg <= result_node_next;
        path_length_reg <= path_length_next;
        status_reg      <= status_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        root_reg        <= root_next;
        v_reg           <= v_next;
        u_reg           <= u_next;
        w_reg           <= w_next;
        tv_reg          <= tv_next;
        p_reg           <= p_next;
        dv_reg          <= dv_next;
        da_reg          <= da_next;
        db_reg          <= db_next;
        k_reg           <= k_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign result_node = result_node_reg;
    assign path_length = path_length_reg;
    assign status      = status_reg;

    a_add_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == tlca_pkg::OP_ADD) |=> (done && !busy))
        else $error("add edge did not complete in one cycle");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != tlca_pkg::ST_OK) |-> (result_node == '0 && path_length == '0))
        else $error("error result carries nonzero payload");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result without a transfer");

    a_edge_cap: assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= EW'(MAX_NODES))
        else $error("edge count beyond capacity");

endmodule

`default_nettype wire

// ===== test/tlca_checker.sv =====
// ----------------------------------------------------------------------------
// tlca_checker: result checker for the tree ancestor engine
// Watches the command, result and configuration channels. It keeps its own
// edge list, ancestor table and depths, predicts each item's result when the
// item transfers, and compares every result field against the oldest
// prediction. It reports the error count and the number of results owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tlca_checker
    import tlca_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [OP_W-1:0]   operation,
    input  logic [NODE_W-1:0] node_a,
    input  logic [NODE_W-1:0] node_b,
    input  logic [NODE_W-1:0] root,
    input  logic [NODE_W-1:0] steps_up,
    input  logic              done,
    input  logic [NODE_W-1:0] result_node,
    input  logic [LEN_W-1:0]  path_length,
    input  logic [ST_W-1:0]   status,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data,
    output int                errors,
    output int                outstanding
);

    localparam int NODES  = DEF_MAX_NODES;
    localparam int LEVELS = DEF_LIFT_LEVELS;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [LEN_W-1:0]  len;
        status_t           st;
    } answer_t;

    answer_t          owed_answers[$];
    int unsigned      ancestor[LEVELS][NODES];
    int unsigned      depth_of[NODES];
    int unsigned      end_a[NODES];
    int unsigned      end_b[NODES];
    int unsigned      edges_held;
    logic [CNT_W-1:0] node_count;

    function automatic int unsigned nodes_in_use();
        if (node_count == 0)
            return 1;
        if (node_count > NODES)
            return NODES;
        return node_count;
    endfunction

    function automatic int unsigned lift(int unsigned v, int unsigned k);
        for (int i = 0; i < LEVELS; i++)
            if (k[i])
                v = ancestor[i][v];
        return v;
    endfunction

    function automatic int unsigned meet(int unsigned v, int unsigned u);
        int unsigned t;
        if (depth_of[v] < depth_of[u])
        begin
            t = v;
            v = u;
            u = t;
        end
        v = lift(v, (depth_of[v] - depth_of[u]) & 32'h3FF);
        if (v == u)
            return v;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (ancestor[i][v] != ancestor[i][u])
            begin
                v = ancestor[i][v];
                u = ancestor[i][u];
            end
        end
        return ancestor[0][v];
    endfunction

    function automatic void grow_tree(int unsigned r, int unsigned n);
        bit          visited[NODES];
        int unsigned pending_nodes[NODES];
        int unsigned sp;
        int unsigned v;
        int unsigned w;
        sp = 0;
        ancestor[0][r] = r;
        depth_of[r] = 0;
        visited[r] = 1;
        pending_nodes[sp++] = r;
        while (sp > 0)
        begin
            v = pending_nodes[--sp];
            for (int e = 0; e < edges_held; e++)
            begin
                if (end_a[e] >= n || end_b[e] >= n)
                    continue;
                if (end_a[e] == v)
                    w = end_b[e];
                else if (end_b[e] == v)
                    w = end_a[e];
                else
                    continue;
                if (visited[w])
                    continue;
                visited[w] = 1;
                ancestor[0][w] = v;
                depth_of[w] = depth_of[v] + 1;
                if (sp < NODES)
                    pending_nodes[sp++] = w;
            end
        end
        for (int i = 1; i < LEVELS; i++)
            for (int j = 0; j < NODES; j++)
                ancestor[i][j] = ancestor[i-1][ancestor[i-1][j]];
    endfunction

    function automatic answer_t predict_answer(op_t op, int unsigned a, int unsigned b,
                                               int unsigned r, int unsigned k);
        answer_t     ans;
        int unsigned n;
        int unsigned p;
        int unsigned sum;
        int unsigned sub;
        n = nodes_in_use();
        ans = '0;
        ans.st = ST_OK;
        case (op)
            OP_ADD:
            begin
                if (a >= n || b >= n)
                    ans.st = ST_RANGE;
                else if (edges_held >= NODES)
                    ans.st = ST_FULL;
                else
                begin
                    end_a[edges_held] = a;
                    end_b[edges_held] = b;
                    edges_held++;
                end
            end
            OP_BUILD:
            begin
                if (r >= n)
                    ans.st = ST_RANGE;
                else
                    grow_tree(r, n);
            end
            OP_LCA:
            begin
                if (a >= n || b >= n)
                    ans.st = ST_RANGE;
                else
                begin
                    p = meet(a, b);
                    sum = depth_of[a] + depth_of[b];
                    sub = 2 * depth_of[p];
                    ans.node = p[NODE_W-1:0];
                    ans.len = (sum > sub) ? LEN_W'(sum - sub) : '0;
                end
            end
            default:
            begin
                if (a >= n)
                    ans.st = ST_RANGE;
                else
                    ans.node = NODE_W'(lift(a, k));
            end
        endcase
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            owed_answers.delete();
            for (int i = 0; i < LEVELS; i++)
                for (int j = 0; j < NODES; j++)
                    ancestor[i][j] = 0;
            for (int j = 0; j < NODES; j++)
                depth_of[j] = 0;
            edges_held = 0;
            node_count = NODE_COUNT_RESET;
            errors = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                node_count = cfg_data;
            if (start && !busy)
                owed_answers = {owed_answers,
                                predict_answer(operation, node_a, node_b, root, steps_up)};
            if (done)
            begin
                if (owed_answers.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result: node %0d length %0d status %0d",
                                 result_node, path_length, status);
                    errors++;
                end
                else
                begin
                    want = owed_answers.pop_front();
                    if (want.node !== result_node || want.len !== path_length
                        || want.st !== status)
                    begin
                        if (errors < 10)
                            $display("result differs: node %0d/%0d length %0d/%0d status %0d/%0d",
                                     want.node, result_node, want.len, path_length,
                                     want.st, status);
                        errors++;
                    end
                end
            end
            outstanding = owed_answers.size();
        end
    end

endmodule

// ===== test/tb_tree_lca_binary_lifting.sv =====
// ----------------------------------------------------------------------------
// tb_tree_lca_binary_lifting: testbench for the tree ancestor engine
// Drives directed edge, build, query and level items at the extremes, then
// random trees under several node counts with noise edges, stale edges and
// out-of-range nodes, and finally queries a small tree after a fresh build.
// Gaps are random, none in some phases; a checker module predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tree_lca_binary_lifting;
    import tlca_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   operation;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] root;
    logic [NODE_W-1:0] steps_up;
    logic              done;
    logic [NODE_W-1:0] result_node;
    logic [LEN_W-1:0]  path_length;
    logic [ST_W-1:0]   status;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data;
    int                errors;
    int                outstanding;
    int                quiet_cycles;
    int                live_n;
    bit                no_gaps;
    int unsigned       labels[1024];

    tree_lca_binary_lifting uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .node_a(node_a), .node_b(node_b), .root(root),
        .steps_up(steps_up), .done(done), .result_node(result_node),
        .path_length(path_length), .status(status), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    tlca_checker result_check (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .node_a(node_a), .node_b(node_b), .root(root),
        .steps_up(steps_up), .done(done), .result_node(result_node),
        .path_length(path_length), .status(status), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data), .errors(errors),
        .outstanding(outstanding)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tree_lca_binary_lifting: mismatch");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 0;
        if (r < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic send(op_t op, int a, int b, int r, int k);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        node_a    <= NODE_W'(a);
        node_b    <= NODE_W'(b);
        root      <= NODE_W'(r);
        steps_up  <= NODE_W'(k);
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
    endtask

    task automatic set_node_count(int value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= CNT_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        live_n = (value == 0) ? 1 : (value > 1024 ? 1024 : value);
    endtask

    function automatic int far_node();
        return (live_n < 1024) ? $urandom_range(live_n, 1023) : $urandom_range(0, 1023);
    endfunction

    task automatic random_phase(int value);
        int m;
        int j;
        int t;
        int p;
        int r;
        set_node_count(value);
        no_gaps = ($urandom_range(0, 3) == 0);
        m = (live_n <= 64) ? live_n : 30;
        for (int i = 0; i < m; i++)
            labels[i] = (live_n <= 64) ? i : $urandom_range(0, 1023);
        for (int i = m - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = labels[i];
            labels[i] = labels[j];
            labels[j] = t;
        end
        for (int i = 1; i < m; i++)
        begin
            p = labels[$urandom_range(0, i - 1)];
            if ($urandom_range(0, 1))
                send(OP_ADD, labels[i], p, $urandom_range(0, 1023), $urandom_range(0, 1023));
            else
                send(OP_ADD, p, labels[i], $urandom_range(0, 1023), $urandom_range(0, 1023));
        end
        send(OP_ADD, labels[0], labels[0], 0, 0);
        send(OP_ADD, labels[$urandom_range(0, m - 1)], labels[$urandom_range(0, m - 1)], 0, 0);
        send(OP_ADD, far_node(), labels[0], 0, 0);
        send(OP_BUILD, 0, 0, labels[$urandom_range(0, m - 1)], 0);
        for (int i = 0; i < 62; i++)
        begin
            if (i == 40)
                send(OP_BUILD, $urandom_range(0, 1023), 0, labels[$urandom_range(0, m - 1)], 0);
            r = $urandom_range(0, 19);
            if (r < 9)
                send(OP_LCA, labels[$urandom_range(0, m - 1)], labels[$urandom_range(0, m - 1)],
                     $urandom_range(0, 1023), $urandom_range(0, 1023));
            else if (r < 16)
                send(OP_LEVEL, labels[$urandom_range(0, m - 1)], $urandom_range(0, 1023),
                     $urandom_range(0, 1023),
                     $urandom_range(0, 1) ? $urandom_range(0, m) : $urandom_range(0, 1023));
            else if (r < 17)
                send(OP_LCA, far_node(), $urandom_range(0, 1023), 0, 0);
            else if (r < 18)
                send(OP_LEVEL, far_node(), 0, 0, $urandom_range(0, 1023));
            else if (r < 19)
                send(OP_BUILD, 0, 0, far_node(), 0);
            else
                send(OP_ADD, labels[$urandom_range(0, m - 1)], labels[$urandom_range(0, m - 1)],
                     0, 0);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_ADD;
        node_a       = '0;
        node_b       = '0;
        root         = '0;
        steps_up     = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        quiet_cycles = 0;
        live_n       = 1024;
        no_gaps      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        send(OP_LCA, 0, 1023, 0, 0);
        send(OP_LEVEL, 1023, 0, 0, 1023);
        send(OP_LEVEL, 5, 0, 0, 0);
        send(OP_ADD, 0, 1023, 0, 0);
        send(OP_ADD, 1023, 512, 0, 0);
        send(OP_ADD, 7, 7, 0, 0);
        send(OP_BUILD, 0, 0, 1023, 0);
        send(OP_LCA, 0, 512, 0, 0);
        send(OP_LEVEL, 512, 0, 0, 1023);
        send(OP_LEVEL, 512, 0, 0, 1);
        send(OP_LCA, 512, 512, 0, 0);
        set_node_count(3);
        send(OP_ADD, 3, 900, 0, 0);
        send(OP_BUILD, 0, 0, 1023, 0);
        send(OP_LCA, 1, 1000, 0, 0);
        send(OP_LEVEL, 1000, 0, 0, 0);
        set_node_count(0);
        send(OP_BUILD, 0, 0, 0, 0);
        send(OP_LCA, 0, 0, 0, 0);
        send(OP_LEVEL, 0, 0, 0, 5);
        send(OP_ADD, 0, 1, 0, 0);

        random_phase(8);
        random_phase(40);
        random_phase(2);
        random_phase(24);
        random_phase(2047);
        random_phase(13);

        set_node_count(16);
        no_gaps = 1'b0;
        send(OP_BUILD, 0, 0, $urandom_range(0, 15), 0);
        for (int i = 0; i < 12; i++)
            send(OP_LCA, $urandom_range(0, 15), $urandom_range(0, 15), 0, 0);
        for (int i = 0; i < 8; i++)
            send(OP_LEVEL, $urandom_range(0, 15), 0, 0, $urandom_range(0, 1023));
        set_node_count(1024);
        send(OP_LCA, 1023, 0, 0, 0);

        settle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("tree_lca_binary_lifting: match");
        else
            $display("tree_lca_binary_lifting: mismatch");
        $finish;
    end

endmodule
